[design/stbp_pkg.sv]
package stbp_pkg;

    localparam int PROJ_WIDTH_DEF  = 1024;
    localparam int PROJ_HEIGHT_DEF = 1024;
    localparam int MAX_VOL_DIM_DEF = 1024;

    // widest store address over the whole parameter range (4096 x 4096)
    localparam int ADDR_W_MAX  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_AW      = 5;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_X_START,
        REG_X_STEP,
        REG_Y_START,
        REG_Y_ROW_STEP,
        REG_Y_SLICE_STEP,
        REG_VOL_NX,
        REG_VOL_NY,
        REG_VOL_NZ
    } reg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_VOXEL = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [19:0]        pixel_index;
        logic signed [31:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [31:0] voxel_value;
        logic               inside_res;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [31:0] x_start;
        logic signed [31:0] x_step;
        logic signed [31:0] y_start;
        logic signed [31:0] y_row_step;
        logic signed [31:0] y_slice_step;
        logic [10:0]        vol_nx;
        logic [10:0]        vol_ny;
        logic [10:0]        vol_nz;
    } cfg_t;

    // one classified operation between front and back
    typedef struct packed {
        logic                  is_load;
        logic [ADDR_W_MAX-1:0] addr;
        logic signed [31:0]    sample;
        logic [15:0]           frac_x;
        logic [15:0]           frac_y;
        logic                  in_image;
        logic                  last;
    } qent_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } back_state_t;

endpackage

[design/stbp_ram.sv]
module stbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/stbp_queue.sv]
module stbp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stbp_pkg::qent_t push_ent,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output stbp_pkg::qent_t head
);

    import stbp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    qent_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

[design/stbp_front.sv]
module stbp_front #(
    parameter int PROJ_WIDTH  = stbp_pkg::PROJ_WIDTH_DEF,
    parameter int PROJ_HEIGHT = stbp_pkg::PROJ_HEIGHT_DEF,
    parameter int MAX_VOL_DIM = stbp_pkg::MAX_VOL_DIM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  stbp_pkg::cfg_t  cfg,
    input  logic            item_valid,
    output logic            item_stall,
    input  stbp_pkg::item_t item,
    output logic            push,
    output stbp_pkg::qent_t push_ent,
    input  logic            q_full
);

    import stbp_pkg::*;

    localparam int CW = (MAX_VOL_DIM > 1) ? $clog2(MAX_VOL_DIM) : 1;
    localparam int NW = $clog2(MAX_VOL_DIM + 1) + 1;
    localparam int STORE_SIZE = PROJ_WIDTH * PROJ_HEIGHT;
    localparam logic signed [31:0] COL_LIM = 32'((PROJ_WIDTH - 1) * 65536);
    localparam logic signed [31:0] ROW_LIM = 32'((PROJ_HEIGHT - 1) * 65536);

    logic [CW-1:0]      col_cnt_reg, col_cnt_next;
    logic [CW-1:0]      row_cnt_reg, row_cnt_next;
    logic [CW-1:0]      slice_cnt_reg, slice_cnt_next;
    logic signed [31:0] col_coord_reg, col_coord_next;
    logic signed [31:0] row_coord_reg, row_coord_next;
    logic signed [31:0] slice_coord_reg, slice_coord_next;

    logic               accept;
    logic               at_origin;
    logic signed [31:0] cur_c, cur_r, cur_s;
    logic               in_image;
    logic [31:0]        pix_addr;
    logic               load_ok;
    logic               last;
    logic [NW-1:0]      nx, ny, nz;
    logic [NW-1:0]      col_p1, row_p1, slice_p1;

    // zero counts as one, anything above the maximum clamps to it
    function automatic logic [NW-1:0] eff_dim(input logic [10:0] n);
        logic [31:0] n32;
        n32 = 32'(n);
        if (n32 == 32'd0)
        begin
            return NW'(1);
        end
        else if (n32 > 32'(MAX_VOL_DIM))
        begin
            return NW'(MAX_VOL_DIM);
        end
        return NW'(n32);
    endfunction

    assign accept     = item_valid && !q_full;
    assign item_stall = q_full;

    assign nx = eff_dim(cfg.vol_nx);
    assign ny = eff_dim(cfg.vol_ny);
    assign nz = eff_dim(cfg.vol_nz);

    assign at_origin = (col_cnt_reg == '0) && (row_cnt_reg == '0) && (slice_cnt_reg == '0);
    assign cur_c = at_origin ? cfg.x_start : col_coord_reg;
    assign cur_r = at_origin ? cfg.y_start : row_coord_reg;
    assign cur_s = at_origin ? cfg.y_start : slice_coord_reg;

    assign in_image = (cur_c > 32'sd0) && (cur_c < COL_LIM) &&
                      (cur_r > 32'sd0) && (cur_r < ROW_LIM);

    assign pix_addr = 32'(cur_r[31:16]) * 32'(PROJ_WIDTH) + 32'(cur_c[31:16]);
    assign load_ok  = 32'(item.pixel_index) < 32'(STORE_SIZE);

    assign col_p1   = NW'(col_cnt_reg) + NW'(1);
    assign row_p1   = NW'(row_cnt_reg) + NW'(1);
    assign slice_p1 = NW'(slice_cnt_reg) + NW'(1);

    always_comb
    begin
        col_cnt_next     = col_cnt_reg;
        row_cnt_next     = row_cnt_reg;
        slice_cnt_next   = slice_cnt_reg;
        col_coord_next   = col_coord_reg;
        row_coord_next   = row_coord_reg;
        slice_coord_next = slice_coord_reg;
        last             = 1'b0;
        if (accept && item.opcode == OP_VOXEL)
        begin
            row_coord_next   = cur_r;
            slice_coord_next = cur_s;
            if (col_p1 < nx)
            begin
                col_cnt_next   = CW'(col_p1);
                col_coord_next = cur_c + cfg.x_step;
            end
            else
            begin
                col_cnt_next   = '0;
                col_coord_next = cfg.x_start;
                if (row_p1 < ny)
                begin
                    row_cnt_next   = CW'(row_p1);
                    row_coord_next = cur_r + cfg.y_row_step;
                end
                else
                begin
                    row_cnt_next = '0;
                    if (slice_p1 < nz)
                    begin
                        slice_cnt_next   = CW'(slice_p1);
                        slice_coord_next = cur_s + cfg.y_slice_step;
                        row_coord_next   = cur_s + cfg.y_slice_step;
                    end
                    else
                    begin
                        slice_cnt_next = '0;
                        last           = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        push_ent.is_load  = (item.opcode == OP_LOAD);
        push_ent.addr     = (item.opcode == OP_LOAD) ? ADDR_W_MAX'(item.pixel_index)
                                                     : ADDR_W_MAX'(pix_addr);
        push_ent.sample   = item.sample;
        push_ent.frac_x   = cur_c[15:0];
        push_ent.frac_y   = cur_r[15:0];
        push_ent.in_image = in_image;
        push_ent.last     = last;
    end

    // out-of-range loads are dropped here
    assign push = accept && ((item.opcode == OP_VOXEL) || load_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            slice_cnt_reg   <= '0;
            col_coord_reg   <= '0;
            row_coord_reg   <= '0;
            slice_coord_reg <= '0;
        end
        else
        begin
            col_cnt_reg     <= col_cnt_next;
            row_cnt_reg     <= row_cnt_next;
            slice_cnt_reg   <= slice_cnt_next;
            col_coord_reg   <= col_coord_next;
            row_coord_reg   <= row_coord_next;
            slice_coord_reg <= slice_coord_next;
        end
    end

endmodule

[design/stbp_back.sv]
module stbp_back #(
    parameter int PROJ_WIDTH  = stbp_pkg::PROJ_WIDTH_DEF,
    parameter int PROJ_HEIGHT = stbp_pkg::PROJ_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  stbp_pkg::qent_t   q_ent,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output stbp_pkg::result_t result
);

    import stbp_pkg::*;

    localparam int STORE_SIZE = PROJ_WIDTH * PROJ_HEIGHT;
    localparam int AW = $clog2(STORE_SIZE);

    back_state_t        state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    qent_t              ent_reg, ent_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic [32:0]        w_reg;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [31:0]        ram_rdata;
    logic [16:0]        wx, wy;
    logic signed [65:0] prod_full;
    logic signed [63:0] rounded;
    logic signed [32:0] sum33;
    logic signed [31:0] add32;
    logic signed [31:0] sat_val;
    logic               out_free;

    stbp_ram #(
        .WIDTH (32),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_ent.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = AW'(q_ent.addr);

    // neighbor order: top-left, top-right, bottom-left, bottom-right
    assign ram_raddr = AW'(ent_reg.addr) + (step_reg[0] ? AW'(1) : AW'(0)) +
                       (step_reg[1] ? AW'(PROJ_WIDTH) : AW'(0));
    assign wx = step_reg[0] ? {1'b0, ent_reg.frac_x} : 17'h10000 - {1'b0, ent_reg.frac_x};
    assign wy = step_reg[1] ? {1'b0, ent_reg.frac_y} : 17'h10000 - {1'b0, ent_reg.frac_y};
    assign prod_full = $signed(ram_rdata) * $signed({1'b0, w_reg});

    assign rounded = acc_reg + 64'sh0000_0000_8000_0000;
    assign add32   = rounded[63:32];
    assign sum33   = {ent_reg.sample[31], ent_reg.sample} + {add32[31], add32};
    always_comb
    begin
        if (sum33[32] != sum33[31])
        begin
            sat_val = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            sat_val = sum33[31:0];
        end
    end

    assign out_free = !res_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ent_next       = ent_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;
        pop            = 1'b0;
        ram_we         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_ent.is_load)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        ent_next   = q_ent;
                        acc_next   = '0;
                        step_next  = '0;
                        state_next = q_ent.in_image ? B_RUN : B_DONE;
                    end
                end
            end
            B_RUN:
            begin
                // reads at steps 0..3; each product is registered and summed in at steps 2..5
                if (step_reg >= 3'd2)
                begin
                    acc_next = acc_reg + prod_reg;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    res_next.voxel_value = ent_reg.in_image ? sat_val : ent_reg.sample;
                    res_next.inside_res  = ent_reg.in_image;
                    res_next.last        = ent_reg.last;
                    res_valid_next       = 1'b1;
                    state_next           = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        w_reg    <= 33'(wx) * 33'(wy);
        prod_reg <= prod_full[63:0];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

[design/single_axis_tilt_backprojection.sv]
// Backprojection of one projection into a volume, single tilt axis.
// Input channel (item_valid/item_stall/item): opcode 0 writes a Q16.16 pixel
// into the projection store, opcode 1 carries the next voxel in raster order
// (x fastest) and produces one transfer on the result channel
// (result_valid/result_stall/result). Loads produce nothing.
// Items pass through a two-entry queue between the classifying front end and
// the execution back end. A voxel inside the image takes longer in the back
// end than one outside, set by the four sequential reads of the store's
// single read port and the shared multiply-accumulate. Results sit in an
// output register; while result_stall is high the back end holds its finished
// voxel and takes no further items, the queue fills, and then item_stall
// rises. Reset clears the counters, queue and output valid; the store content
// is undefined until written. Configuration goes through the APB port
// (registers at byte offsets 4*i); the user must write it only while the
// block is idle, as the block itself does not enforce this.
module single_axis_tilt_backprojection #(
    parameter int PROJ_WIDTH  = stbp_pkg::PROJ_WIDTH_DEF,
    parameter int PROJ_HEIGHT = stbp_pkg::PROJ_HEIGHT_DEF,
    parameter int MAX_VOL_DIM = stbp_pkg::MAX_VOL_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stbp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  stbp_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output stbp_pkg::result_t           result
);

    import stbp_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t wr_idx;
    reg_index_t rd_idx;
    logic       cfg_wr;
    logic       push, q_full, q_valid, pop;
    qent_t      push_ent, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = reg_index_t'(paddr[4:2]);
    assign rd_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_start      <= '0;
            cfg_reg.x_step       <= ONE_Q16;
            cfg_reg.y_start      <= '0;
            cfg_reg.y_row_step   <= ONE_Q16;
            cfg_reg.y_slice_step <= '0;
            cfg_reg.vol_nx       <= 11'd1024;
            cfg_reg.vol_ny       <= 11'd1024;
            cfg_reg.vol_nz       <= 11'd1024;
        end
        else if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_X_START:      cfg_reg.x_start      <= pwdata;
                REG_X_STEP:       cfg_reg.x_step       <= pwdata;
                REG_Y_START:      cfg_reg.y_start      <= pwdata;
                REG_Y_ROW_STEP:   cfg_reg.y_row_step   <= pwdata;
                REG_Y_SLICE_STEP: cfg_reg.y_slice_step <= pwdata;
                REG_VOL_NX:       cfg_reg.vol_nx       <= pwdata[10:0];
                REG_VOL_NY:       cfg_reg.vol_ny       <= pwdata[10:0];
                REG_VOL_NZ:       cfg_reg.vol_nz       <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (rd_idx)
            REG_X_START:      prdata = cfg_reg.x_start;
            REG_X_STEP:       prdata = cfg_reg.x_step;
            REG_Y_START:      prdata = cfg_reg.y_start;
            REG_Y_ROW_STEP:   prdata = cfg_reg.y_row_step;
            REG_Y_SLICE_STEP: prdata = cfg_reg.y_slice_step;
            REG_VOL_NX:       prdata = 32'(cfg_reg.vol_nx);
            REG_VOL_NY:       prdata = 32'(cfg_reg.vol_ny);
            REG_VOL_NZ:       prdata = 32'(cfg_reg.vol_nz);
            default:          prdata = '0;
        endcase
    end

    stbp_front #(
        .PROJ_WIDTH  (PROJ_WIDTH),
        .PROJ_HEIGHT (PROJ_HEIGHT),
        .MAX_VOL_DIM (MAX_VOL_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_ent   (push_ent),
        .q_full     (q_full)
    );

    stbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    stbp_back #(
        .PROJ_WIDTH  (PROJ_WIDTH),
        .PROJ_HEIGHT (PROJ_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ent        (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import stbp_pkg::*;

    localparam int PW = 1024;
    localparam int PH = 1024;
    localparam int MAXD = 1024;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic item_valid, item_stall;
    item_t item;
    logic result_valid, result_stall;
    result_t result;

    single_axis_tilt_backprojection DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor state
    logic [31:0] pixels [int unsigned];
    logic [31:0] r_x_start, r_x_step, r_y_start, r_y_row_step, r_y_slice_step;
    logic [10:0] r_nx, r_ny, r_nz;
    int unsigned n_col, n_row, n_slice;
    logic [31:0] c_col, c_row, c_slice;

    item_t   pending_items[$];
    result_t expected_voxels[$];
    int errors;
    int mismatches;
    int cycles;
    bit in_xfer;

    function automatic int unsigned clamp_dim(logic [10:0] n);
        if (n == 0)
            return 1;
        if (n > MAXD)
            return MAXD;
        return n;
    endfunction

    function automatic longint pixel_at(int unsigned a);
        if (pixels.exists(a))
            return longint'(signed'(pixels[a]));
        return 0;
    endfunction

    // update predictor for one accepted item
    task automatic predict_backprojection(item_t it);
        int unsigned nx, ny, nz, ci, ri, a;
        longint c, r, acc, wux, wlx, wuy, wly, top, bot, fv;
        logic [63:0] u;
        bit ins, lst;
        result_t res;
        nx = clamp_dim(r_nx);
        ny = clamp_dim(r_ny);
        nz = clamp_dim(r_nz);
        if (it.opcode == OP_LOAD)
        begin
            if (it.pixel_index < PW * PH)
                pixels[it.pixel_index] = it.sample;
            return;
        end
        if (n_col == 0 && n_row == 0 && n_slice == 0)
        begin
            c_slice = r_y_start;
            c_row = r_y_start;
            c_col = r_x_start;
        end
        c = longint'(signed'(c_col));
        r = longint'(signed'(c_row));
        ins = c > 0 && c < longint'(PW - 1) * 65536 && r > 0 && r < longint'(PH - 1) * 65536;
        acc = longint'(it.sample);
        if (ins)
        begin
            ci = c >>> 16;
            ri = r >>> 16;
            wux = c & 16'hFFFF;
            wlx = 65536 - wux;
            wuy = r & 16'hFFFF;
            wly = 65536 - wuy;
            a = ri * PW + ci;
            top = wlx * pixel_at(a) + wux * pixel_at(a + 1);
            bot = wlx * pixel_at(a + PW) + wux * pixel_at(a + PW + 1);
            fv = top * wly + bot * wuy;
            u = 64'(fv) + 64'h8000_0000;
            acc += longint'(signed'(u[63:32]));
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
        end
        lst = 1'b0;
        if (n_col + 1 < nx)
        begin
            n_col++;
            c_col += r_x_step;
        end
        else
        begin
            n_col = 0;
            c_col = r_x_start;
            if (n_row + 1 < ny)
            begin
                n_row++;
                c_row += r_y_row_step;
            end
            else
            begin
                n_row = 0;
                if (n_slice + 1 < nz)
                begin
                    n_slice++;
                    c_slice += r_y_slice_step;
                    c_row = c_slice;
                end
                else
                begin
                    n_slice = 0;
                    lst = 1'b1;
                end
            end
        end
        res.voxel_value = acc[31:0];
        res.inside_res = ins;
        res.last = lst;
        expected_voxels.push_back(res);
    endtask

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (item_valid && !in_xfer)
        begin
        end
        else if (gap_left > 0)
        begin
            item_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_items.size() > 0)
        begin
            item_valid <= 1'b1;
            item <= pending_items.pop_front();
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            item_valid <= 1'b0;
    end

    // receiver stall pattern
    int stall_mode;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ~result_stall;
                default: result_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        in_xfer <= rst_n && item_valid && !item_stall;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (item_valid && !item_stall)
                predict_backprojection(item);
            if (result_valid && !result_stall)
            begin
                if (expected_voxels.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected result %h", result);
                    mismatches++;
                end
                else
                begin
                    result_t e;
                    e = expected_voxels.pop_front();
                    if (e.voxel_value !== result.voxel_value || e.inside_res !== result.inside_res
                        || e.last !== result.last)
                    begin
                        errors++;
                        if (mismatches < 10)
                            $display("mismatch: expected %h %b %b, got %h %b %b",
                                e.voxel_value, e.inside_res, e.last,
                                result.voxel_value, result.inside_res, result.last);
                        mismatches++;
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_X_START: r_x_start = val;
            REG_X_STEP: r_x_step = val;
            REG_Y_START: r_y_start = val;
            REG_Y_ROW_STEP: r_y_row_step = val;
            REG_Y_SLICE_STEP: r_y_slice_step = val;
            REG_VOL_NX: r_nx = val[10:0];
            REG_VOL_NY: r_ny = val[10:0];
            default: r_nz = val[10:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || item_valid || expected_voxels.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic item_t mk(opcode_t op, logic [19:0] idx, logic [31:0] s);
        item_t it;
        it.opcode = op;
        it.pixel_index = idx;
        it.sample = s;
        return it;
    endfunction

    // loads the 8x8 pixel window at rows/cols base..base+7
    task automatic load_window(int base);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                pending_items.push_back(mk(OP_LOAD, 20'((base + r) * PW + base + c), $urandom));
    endtask

    task automatic random_phase(int base, int n_items);
        logic [31:0] v;
        // close a partial volume while the old window is still in use
        reg_write(REG_VOL_NX, 11'd1);
        reg_write(REG_VOL_NY, 11'd1);
        reg_write(REG_VOL_NZ, 11'd1);
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        wait_idle();
        reg_write(REG_X_START, 32'((base + 3) * 65536 + $urandom_range(0, 65535)));
        reg_write(REG_X_STEP, $urandom_range(0, 40000) - 20000);
        reg_write(REG_Y_START, 32'((base + 3) * 65536 + $urandom_range(0, 65535)));
        reg_write(REG_Y_ROW_STEP, $urandom_range(0, 40000) - 20000);
        reg_write(REG_Y_SLICE_STEP, $urandom_range(0, 40000) - 20000);
        reg_write(REG_VOL_NX, $urandom_range(1, 6));
        reg_write(REG_VOL_NY, $urandom_range(1, 5));
        reg_write(REG_VOL_NZ, $urandom_range(1, 4));
        load_window(base);
        for (int i = 0; i < n_items; i++)
        begin
            case ($urandom_range(0, 9))
                0: pending_items.push_back(mk(OP_LOAD, 20'($urandom), $urandom));
                1: pending_items.push_back(mk(OP_LOAD,
                    20'((base + $urandom_range(0, 7)) * PW + base + $urandom_range(0, 7)),
                    $urandom));
                2:
                begin
                    v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3) :
                        32'h8000_0000 + $urandom_range(0, 3);
                    pending_items.push_back(mk(OP_VOXEL, 20'($urandom), v));
                end
                default: pending_items.push_back(mk(OP_VOXEL, 20'($urandom), $urandom));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        r_x_start = 0;
        r_x_step = ONE_Q16;
        r_y_start = 0;
        r_y_row_step = ONE_Q16;
        r_y_slice_step = 0;
        r_nx = 11'd1024;
        r_ny = 11'd1024;
        r_nz = 11'd1024;
        n_col = 0;
        n_row = 0;
        n_slice = 0;
        c_col = 0;
        c_row = 0;
        c_slice = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, voxels at origin lie on the border
        pending_items.push_back(mk(OP_VOXEL, 20'hFFFFF, 32'h7FFF_FFFF));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h8000_0000));
        wait_idle();
        // finish that volume quickly: shrink dims so counters wrap
        reg_write(REG_VOL_NX, 11'd0);
        reg_write(REG_VOL_NY, 11'd2047);
        reg_write(REG_VOL_NZ, 11'd1);
        reg_write(REG_VOL_NY, 11'd1);
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        wait_idle();
        // saturation with extreme pixels, load at the last store address, edge coords
        reg_write(REG_X_START, 32'h0001_8000);
        reg_write(REG_X_STEP, 32'h8000_0000);
        reg_write(REG_Y_START, 32'h0001_0000);
        reg_write(REG_Y_ROW_STEP, 32'h7FFF_FFFF);
        reg_write(REG_Y_SLICE_STEP, 32'h0000_8000);
        reg_write(REG_VOL_NX, 11'd2);
        reg_write(REG_VOL_NY, 11'd2);
        reg_write(REG_VOL_NZ, 11'd2);
        pending_items.push_back(mk(OP_LOAD, 20'hFFFFF, 32'h7FFF_FFFF));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                pending_items.push_back(mk(OP_LOAD, 20'((1 + r) * PW + 1 + c),
                    (r == 0) ? 32'h7FFF_FFFF : 32'h8000_0000));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h7FFF_FFFF));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h8000_0000));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h7FFF_FFFF));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h8000_0000));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h1234_5678));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'hFFFF_FFFF));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        wait_idle();
        // near the far corner of the image
        reg_write(REG_X_START, 32'((PW - 2) * 65536 + 65535));
        reg_write(REG_X_STEP, 32'h0000_0001);
        reg_write(REG_Y_START, 32'((PH - 2) * 65536 + 65535));
        reg_write(REG_Y_ROW_STEP, 32'h0000_0001);
        reg_write(REG_VOL_NX, 11'd2);
        reg_write(REG_VOL_NY, 11'd1);
        reg_write(REG_VOL_NZ, 11'd1);
        load_window(PW - 8);
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        pending_items.push_back(mk(OP_VOXEL, 20'h0, 32'h0));
        wait_idle();

        // random phases: coordinates stay within loaded windows
        for (int p = 0; p < 10; p++)
        begin
            random_phase(8 * $urandom_range(2, 120), 125);
            wait_idle();
        end
        wait_idle();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
